FILE: rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned BlockW     = 128;
  localparam int unsigned HalfW      = 64;
  localparam int unsigned CfgIdxW    = 1;

  typedef logic [BlockW-1:0] block_t;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } cfg_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block, byte 0 most significant
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aes_if.sv
`default_nettype none
interface aes_if;
  logic                   valid;
  logic                   ready;
  logic [aes_pkg::HalfW-1:0] data_high;
  logic [aes_pkg::HalfW-1:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink   (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

FILE: rtl/aes_round_cell.sv
`default_nettype none
// One round of the cipher plus the matching key schedule step, registered.
module aes_round_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic [3:0]           round_i,
  input  wire logic                 last_i,
  input  wire logic                 valid_i,
  input  wire aes_pkg::block_t      state_i,
  input  wire aes_pkg::block_t      key_i,
  output logic                      valid_o,
  output aes_pkg::block_t           state_o,
  output aes_pkg::block_t           key_o
);
  import aes_pkg::*;

  logic [7:0] s   [16];
  logic [7:0] t   [16];
  logic [7:0] m   [16];
  logic [7:0] k   [16];
  logic [7:0] nk  [16];
  block_t     state_d;
  block_t     key_d;
  logic       valid_q;
  block_t     state_q;
  block_t     key_q;

  // SubBytes, ShiftRows, MixColumns
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = get_byte(state_i, i);
      k[i] = get_byte(key_i, i);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = t[4*c]   ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c]^t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+1]^t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+2]^t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+3]^t[4*c]);
    end
    // next round key
    nk[0] = k[0] ^ SBOX[k[13]] ^ RCON[round_i];
    nk[1] = k[1] ^ SBOX[k[14]];
    nk[2] = k[2] ^ SBOX[k[15]];
    nk[3] = k[3] ^ SBOX[k[12]];
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      key_d[BlockW-1-8*i -: 8]   = nk[i];
      state_d[BlockW-1-8*i -: 8] = (last_i ? t[i] : m[i]) ^ nk[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;
endmodule
`default_nettype wire

FILE: rtl/aes128_block_encrypt.sv
`default_nettype none
// AES-128 encryption, one block per item.
// in_if carries plaintext (high half = state bytes 0..7), out_if the ciphertext.
// Configure the key with cfg_we_i/cfg_idx_i/cfg_wdata_i: index 0 = key high half,
// index 1 = key low half; other indexes are ignored. Write only while idle.
// The datapath is a row of ten round cells, each doing one round and one key
// schedule step, passing state and round key on to the next cell each cycle
// while out_if is not stalled; ciphertext leaves the tenth cell to out_if.
// Throughput: one item per cycle unless stalled; the registered cells set this.
// When the receiver stalls, the whole chain holds; in_if.ready falls only when
// the last cell holds a result that is not taken. A stall costs no items.
// Reset clears every cell's valid flag and the key to zero; pending items
// are dropped.
module aes128_block_encrypt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [aes_pkg::HalfW-1:0] cfg_wdata_i,
  aes_if.sink                            in_if,
  aes_if.source                          out_if
);
  import aes_pkg::*;

  logic [HalfW-1:0] key_high_q;
  logic [HalfW-1:0] key_low_q;
  logic             en;
  logic             valid  [NumRounds+1];
  block_t           state  [NumRounds+1];
  block_t           rkey   [NumRounds+1];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegKeyHigh: key_high_q <= cfg_wdata_i;
        RegKeyLow:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // chain advances unless the final result is stalled
  assign en          = !valid[NumRounds] || out_if.ready;
  assign in_if.ready = en;

  // initial AddRoundKey feeds the first cell
  assign valid[0] = in_if.valid;
  assign rkey[0]  = {key_high_q, key_low_q};
  assign state[0] = {in_if.data_high, in_if.data_low} ^ rkey[0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .round_i (4'(g)),
      .last_i  (g == NumRounds - 1),
      .valid_i (valid[g]),
      .state_i (state[g]),
      .key_i   (rkey[g]),
      .valid_o (valid[g+1]),
      .state_o (state[g+1]),
      .key_o   (rkey[g+1])
    );
  end

  assign out_if.valid     = valid[NumRounds];
  assign out_if.data_high = state[NumRounds][BlockW-1:HalfW];
  assign out_if.data_low  = state[NumRounds][HalfW-1:0];

`ifndef SYNTHESIS
  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data_high)
      && $stable(out_if.data_low))
    else $error("result changed under stall");
  // input is refused only while the output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input refused without output stall");
  // an accepted item reaches the output when the chain is never stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready ##1 en ##1 en ##1 en ##1 en ##1 en ##1 en
      ##1 en ##1 en ##1 en |=> out_if.valid)
    else $error("item lost in round chain");
`endif
endmodule
`default_nettype wire
